// ===== rtl/ecr_pkg.sv =====
// ----------------------------------------------------------------------------
// ecr_pkg: shared widths, stage positions and types
// Widths of the fixed-point datapath and the stage at which each value
// becomes available in the elastic collision response pipeline.
// ----------------------------------------------------------------------------
package ecr_pkg;

	// Fraction bits of velocities, unit normal and weights.
	localparam int FRAC_BITS = 16;

	// Field widths.
	localparam int VEL_W  = 32;
	localparam int MASS_W = 32;
	localparam int MAG_W  = 32;
	localparam int ERR_W  = 2;

	// Internal widths.
	localparam int REL_W    = VEL_W + 1;
	localparam int DEN_W    = MASS_W + 1;
	localparam int RAD_W    = 2 * MAG_W;
	localparam int ROOT_W   = MAG_W;
	localparam int SQ_STEPS = ROOT_W;
	localparam int DQW      = FRAC_BITS + 2;
	localparam int UW       = FRAC_BITS + 2;
	localparam int WW       = FRAC_BITS + 2;
	localparam int PRD_W    = REL_W + UW;
	localparam int DOT_W    = PRD_W + 1;
	localparam int P_W      = DOT_W - FRAC_BITS;
	localparam int QP_W     = P_W + WW + 1;
	localparam int Q_W      = QP_W - FRAC_BITS;
	localparam int DP_W     = Q_W + UW;
	localparam int D_W      = DP_W - FRAC_BITS;
	localparam int RES_W    = D_W + 1;

	// Stage at which each value sits in its register.
	localparam int ST_NSH      = 2;
	localparam int ST_SQ       = ST_NSH + 1;
	localparam int ST_RAD      = ST_SQ + 1;
	localparam int ST_LEN      = ST_RAD + SQ_STEPS;
	localparam int ST_UQ       = ST_LEN + DQW;
	localparam int ST_WQ       = DQW;
	localparam int ST_W        = ST_WQ + 1;
	localparam int RESP_STAGES = 6;
	localparam int ST_OUT      = ST_UQ + RESP_STAGES;

	// Error codes.
	localparam logic [ERR_W-1:0] ERR_OK        = ERR_W'(0);
	localparam logic [ERR_W-1:0] ERR_BOTH_INF  = ERR_W'(1);
	localparam logic [ERR_W-1:0] ERR_BOTH_USER = ERR_W'(2);

	// Per-item context that rides along the pipeline.
	typedef struct packed {
		logic signed [VEL_W-1:0] ax;
		logic signed [VEL_W-1:0] ay;
		logic signed [VEL_W-1:0] bx;
		logic signed [VEL_W-1:0] by;
		logic signed [REL_W-1:0] rx;
		logic signed [REL_W-1:0] ry;
		logic                    nx_neg;
		logic                    ny_neg;
		logic                    nrm_zero;
		logic                    a_inf;
		logic                    b_inf;
		logic                    sum_zero;
		logic [ERR_W-1:0]        err;
	} ctx_t;

	typedef struct packed {
		logic [MAG_W-1:0] x;
		logic [MAG_W-1:0] y;
	} mag2_t;

	typedef struct packed {
		logic [WW-1:0] wa;
		logic [WW-1:0] wb;
	} wgt_t;

endpackage

// ===== rtl/ecr_nshift.sv =====
// ----------------------------------------------------------------------------
// ecr_nshift: normal magnitude normalizer
// Shifts both normal magnitudes left by the least amount that brings the
// larger one to at least 2^30. Two register stages.
// ----------------------------------------------------------------------------
module ecr_nshift (
	input  logic                     clk,
	input  logic                     en,
	input  logic [ecr_pkg::MAG_W-1:0] mag_x,
	input  logic [ecr_pkg::MAG_W-1:0] mag_y,
	output logic [ecr_pkg::MAG_W-1:0] norm_x,
	output logic [ecr_pkg::MAG_W-1:0] norm_y
);
	import ecr_pkg::*;

	logic [MAG_W-1:0] ma, xa, ya;
	logic [MAG_W-1:0] mb, xb, yb;
	logic [MAG_W-1:0] m_s1, x_s1, y_s1;
	logic [MAG_W-1:0] x_s2, y_s2;

	// First half of the shift search: steps of 16 and 8.
	always_comb begin
		ma = (mag_x > mag_y) ? mag_x : mag_y;
		xa = mag_x;
		ya = mag_y;
		if (ma[31:15] == '0) begin
			ma = ma << 16;
			xa = xa << 16;
			ya = ya << 16;
		end
		if (ma[31:23] == '0) begin
			ma = ma << 8;
			xa = xa << 8;
			ya = ya << 8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= ma;
			x_s1 <= xa;
			y_s1 <= ya;
		end
	end

	// Second half: steps of 4, 2 and 1.
	always_comb begin
		mb = m_s1;
		xb = x_s1;
		yb = y_s1;
		if (mb[31:27] == '0) begin
			mb = mb << 4;
			xb = xb << 4;
			yb = yb << 4;
		end
		if (mb[31:29] == '0) begin
			mb = mb << 2;
			xb = xb << 2;
			yb = yb << 2;
		end
		if (mb[31:30] == '0) begin
			xb = xb << 1;
			yb = yb << 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= xb;
			y_s2 <= yb;
		end
	end

	assign norm_x = x_s2;
	assign norm_y = y_s2;

endmodule

// ===== rtl/ecr_sqrt.sv =====
// ----------------------------------------------------------------------------
// ecr_sqrt: pipelined integer square root
// Digit-by-digit floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module ecr_sqrt (
	input  logic                      clk,
	input  logic                      en,
	input  logic [ecr_pkg::RAD_W-1:0]  rad,
	output logic [ecr_pkg::ROOT_W-1:0] root
);
	import ecr_pkg::*;

	localparam int REM_W = ROOT_W + 2;

	logic [REM_W-1:0]  rem_s  [1:SQ_STEPS-1];
	logic [RAD_W-1:0]  rad_s  [1:SQ_STEPS-1];
	logic [ROOT_W-1:0] root_s [1:SQ_STEPS];

	for (genvar i = 1; i <= SQ_STEPS; i++) begin : g_step
		logic [REM_W-1:0]  rem_p;
		logic [ROOT_W-1:0] root_p;
		logic [RAD_W-1:0]  rad_p;
		logic [REM_W+1:0]  cat;
		logic [REM_W+1:0]  trial;
		logic              take;

		if (i == 1) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = rad;
		end else begin : g_next
			assign rem_p  = rem_s[i-1];
			assign root_p = root_s[i-1];
			assign rad_p  = rad_s[i-1];
		end

		// Bring down two radicand bits and try the next root bit.
		assign cat   = {rem_p, rad_p[RAD_W-1 -: 2]};
		assign trial = {2'b00, root_p, 2'b01};
		assign take  = (cat >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[i] <= {root_p[ROOT_W-2:0], take};
			end
		end

		if (i < SQ_STEPS) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= take ? REM_W'(cat - trial) : cat[REM_W-1:0];
					rad_s[i] <= rad_p << 2;
				end
			end
		end
	end

	assign root = root_s[SQ_STEPS];

endmodule

// ===== rtl/ecr_div.sv =====
// ----------------------------------------------------------------------------
// ecr_div: pipelined restoring divider
// Produces one quotient bit per register stage. The upper part of the
// dividend (rem0) must be below the divisor.
// ----------------------------------------------------------------------------
module ecr_div (
	input  logic                     clk,
	input  logic                     en,
	input  logic [ecr_pkg::DEN_W-1:0] den,
	input  logic [ecr_pkg::DEN_W-1:0] rem0,
	input  logic [ecr_pkg::DQW-1:0]   lo,
	output logic [ecr_pkg::DQW-1:0]   quo
);
	import ecr_pkg::*;

	logic [DEN_W-1:0] rem_s [1:DQW-1];
	logic [DEN_W-1:0] den_s [1:DQW-1];
	logic [DQW-1:0]   lo_s  [1:DQW-1];
	logic [DQW-1:0]   quo_s [1:DQW];

	for (genvar i = 1; i <= DQW; i++) begin : g_step
		logic [DEN_W-1:0] rem_p;
		logic [DEN_W-1:0] den_p;
		logic [DQW-1:0]   lo_p;
		logic [DQW-1:0]   quo_p;
		logic [DEN_W:0]   cat;
		logic             take;

		if (i == 1) begin : g_first
			assign rem_p = rem0;
			assign den_p = den;
			assign lo_p  = lo;
			assign quo_p = '0;
		end else begin : g_next
			assign rem_p = rem_s[i-1];
			assign den_p = den_s[i-1];
			assign lo_p  = lo_s[i-1];
			assign quo_p = quo_s[i-1];
		end

		// Shift in the next dividend bit and subtract when it fits.
		assign cat  = {rem_p, lo_p[DQW-1]};
		assign take = (cat >= {1'b0, den_p});

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[i] <= {quo_p[DQW-2:0], take};
			end
		end

		if (i < DQW) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= take ? DEN_W'(cat - {1'b0, den_p}) : cat[DEN_W-1:0];
					den_s[i] <= den_p;
					lo_s[i]  <= lo_p << 1;
				end
			end
		end
	end

	assign quo = quo_s[DQW];

endmodule

// ===== rtl/ecr_resp.sv =====
// ----------------------------------------------------------------------------
// ecr_resp: impulse back end
// Builds the signed unit normal, projects the relative velocity on it,
// scales by the mass weights and applies the saturated velocity update.
// Six register stages.
// ----------------------------------------------------------------------------
module ecr_resp (
	input  logic                             clk,
	input  logic                             en,
	input  ecr_pkg::ctx_t                    ctx,
	input  logic [ecr_pkg::DQW-1:0]          ux_quo,
	input  logic [ecr_pkg::DQW-1:0]          uy_quo,
	input  ecr_pkg::wgt_t                    wgt,
	output logic signed [ecr_pkg::VEL_W-1:0] new_a_vel_x,
	output logic signed [ecr_pkg::VEL_W-1:0] new_a_vel_y,
	output logic signed [ecr_pkg::VEL_W-1:0] new_b_vel_x,
	output logic signed [ecr_pkg::VEL_W-1:0] new_b_vel_y,
	output logic [ecr_pkg::ERR_W-1:0]        error_code
);
	import ecr_pkg::*;

	// Clamp a wide result to the signed velocity range.
	function automatic logic [VEL_W-1:0] sat_vel(input logic signed [RES_W-1:0] v);
		logic [VEL_W-1:0] r;
		if ((v[RES_W-1:VEL_W-1] == '0) || (v[RES_W-1:VEL_W-1] == '1)) begin
			r = v[VEL_W-1:0];
		end else if (v[RES_W-1]) begin
			r = {1'b1, {(VEL_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(VEL_W-1){1'b1}}};
		end
		return r;
	endfunction

	ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5;
	wgt_t wgt_s1, wgt_s2, wgt_s3;
	logic signed [UW-1:0]    ux_s1, uy_s1, ux_s2, uy_s2, ux_s3, uy_s3, ux_s4, uy_s4;
	logic signed [PRD_W-1:0] prx_s2, pry_s2;
	logic signed [P_W-1:0]   p_s3;
	logic signed [Q_W-1:0]   qa_s4, qb_s4;
	logic signed [D_W-1:0]   dax_s5, day_s5, dbx_s5, dby_s5;

	logic signed [UW-1:0]    umag_x, umag_y;
	logic signed [DOT_W-1:0] dsum;
	logic signed [QP_W-1:0]  qa_prd, qb_prd;
	logic signed [DP_W-1:0]  dax_prd, day_prd, dbx_prd, dby_prd;
	logic signed [RES_W-1:0] res_ax, res_ay, res_bx, res_by;

	// Stage 1: unit normal components with their signs.
	assign umag_x = $signed({1'b0, ux_quo[DQW-1:1]});
	assign umag_y = $signed({1'b0, uy_quo[DQW-1:1]});

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx;
			wgt_s1 <= wgt;
			if (ctx.nrm_zero) begin
				ux_s1 <= '0;
				uy_s1 <= '0;
			end else begin
				ux_s1 <= ctx.nx_neg ? -umag_x : umag_x;
				uy_s1 <= ctx.ny_neg ? -umag_y : umag_y;
			end
		end
	end

	// Stage 2: relative velocity times unit normal, per axis.
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2 <= ctx_s1;
			wgt_s2 <= wgt_s1;
			ux_s2  <= ux_s1;
			uy_s2  <= uy_s1;
			prx_s2 <= ctx_s1.rx * ux_s1;
			pry_s2 <= ctx_s1.ry * uy_s1;
		end
	end

	// Stage 3: projection, floored.
	assign dsum = prx_s2 + pry_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3 <= ctx_s2;
			wgt_s3 <= wgt_s2;
			ux_s3  <= ux_s2;
			uy_s3  <= uy_s2;
			p_s3   <= dsum[DOT_W-1:FRAC_BITS];
		end
	end

	// Stage 4: projection scaled by each body's weight.
	assign qa_prd = p_s3 * $signed({1'b0, wgt_s3.wa});
	assign qb_prd = p_s3 * $signed({1'b0, wgt_s3.wb});

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s4 <= ctx_s3;
			ux_s4  <= ux_s3;
			uy_s4  <= uy_s3;
			qa_s4  <= qa_prd[QP_W-1:FRAC_BITS];
			qb_s4  <= qb_prd[QP_W-1:FRAC_BITS];
		end
	end

	// Stage 5: velocity change along each axis.
	assign dax_prd = qa_s4 * ux_s4;
	assign day_prd = qa_s4 * uy_s4;
	assign dbx_prd = qb_s4 * ux_s4;
	assign dby_prd = qb_s4 * uy_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s5 <= ctx_s4;
			dax_s5 <= dax_prd[DP_W-1:FRAC_BITS];
			day_s5 <= day_prd[DP_W-1:FRAC_BITS];
			dbx_s5 <= dbx_prd[DP_W-1:FRAC_BITS];
			dby_s5 <= dby_prd[DP_W-1:FRAC_BITS];
		end
	end

	// Stage 6: apply, saturate, or pass through on an error.
	assign res_ax = $signed(ctx_s5.ax) - dax_s5;
	assign res_ay = $signed(ctx_s5.ay) - day_s5;
	assign res_bx = $signed(ctx_s5.bx) + dbx_s5;
	assign res_by = $signed(ctx_s5.by) + dby_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			error_code <= ctx_s5.err;
			if (ctx_s5.err != ERR_OK) begin
				new_a_vel_x <= ctx_s5.ax;
				new_a_vel_y <= ctx_s5.ay;
				new_b_vel_x <= ctx_s5.bx;
				new_b_vel_y <= ctx_s5.by;
			end else begin
				new_a_vel_x <= $signed(sat_vel(res_ax));
				new_a_vel_y <= $signed(sat_vel(res_ay));
				new_b_vel_x <= $signed(sat_vel(res_bx));
				new_b_vel_y <= $signed(sat_vel(res_by));
			end
		end
	end

endmodule

// ===== rtl/elastic_collision_response_2d.sv =====
// ----------------------------------------------------------------------------
// elastic_collision_response_2d: 2D elastic collision velocity update
// Normalizes the contact normal, projects the relative velocity on it and
// applies a mass-weighted elastic impulse to both bodies, in Q16.16.
//
//   Channel  Handshake             Beat contents
//   in       in_valid / in_ready   velocities, masses, flags, contact normal
//   out      out_valid / out_ready new velocities, error_code
//
// One beat enters per cycle while the output is not stalled.
// The pipeline is made of four front stages (two to normalize the normal, one
// to square, one to sum), the 32-stage square root, the 18-stage normal
// divider and the six-stage impulse back end.
// Reset clears only the valid bits of the stages.
// When out_valid is high and out_ready low, every stage holds its contents
// and in_ready drops in the same cycle.
// ----------------------------------------------------------------------------
module elastic_collision_response_2d (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [ecr_pkg::VEL_W-1:0]  a_vel_x,
	input  logic signed [ecr_pkg::VEL_W-1:0]  a_vel_y,
	input  logic signed [ecr_pkg::VEL_W-1:0]  b_vel_x,
	input  logic signed [ecr_pkg::VEL_W-1:0]  b_vel_y,
	input  logic [ecr_pkg::MASS_W-1:0]        a_mass,
	input  logic [ecr_pkg::MASS_W-1:0]        b_mass,
	input  logic                              a_mass_infinite,
	input  logic                              b_mass_infinite,
	input  logic                              a_user_controlled,
	input  logic                              b_user_controlled,
	input  logic signed [ecr_pkg::VEL_W-1:0]  normal_x,
	input  logic signed [ecr_pkg::VEL_W-1:0]  normal_y,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ecr_pkg::VEL_W-1:0]  new_a_vel_x,
	output logic signed [ecr_pkg::VEL_W-1:0]  new_a_vel_y,
	output logic signed [ecr_pkg::VEL_W-1:0]  new_b_vel_x,
	output logic signed [ecr_pkg::VEL_W-1:0]  new_b_vel_y,
	output logic [ecr_pkg::ERR_W-1:0]         error_code
);
	import ecr_pkg::*;

	localparam logic [WW-1:0] W_TWO = WW'(1) << (FRAC_BITS + 1);
	localparam logic [WW-1:0] W_ONE = WW'(1) << FRAC_BITS;

	logic              adv;
	logic [ST_OUT:1]   vld_s;

	logic [MAG_W-1:0]        mag_nx, mag_ny;
	logic signed [REL_W-1:0] ax_e, ay_e, bx_e, by_e;
	logic [DEN_W-1:0]        msum;
	ctx_t                    ctx_in;

	ctx_t             ctx_s [1:ST_UQ];
	logic [MAG_W-1:0] nsx, nsy;
	mag2_t            nm_s  [ST_NSH+1:ST_LEN];
	logic [RAD_W-1:0] sqx_s3, sqy_s3, rad_s4;
	logic [ROOT_W-1:0] len;
	logic [DQW-1:0]   ux_quo, uy_quo, wa_quo, wb_quo;
	wgt_t             wgt_in;
	wgt_t             w_s   [ST_W:ST_UQ];

	// Whole-pipeline advance: hold everything while a result waits.
	assign adv       = !vld_s[ST_OUT] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_s[ST_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[ST_OUT-1:1], in_valid};
		end
	end

	// Input stage: magnitudes, relative velocity, error code.
	assign mag_nx = normal_x[VEL_W-1] ? (~normal_x + MAG_W'(1)) : normal_x;
	assign mag_ny = normal_y[VEL_W-1] ? (~normal_y + MAG_W'(1)) : normal_y;
	assign ax_e   = {a_vel_x[VEL_W-1], a_vel_x};
	assign ay_e   = {a_vel_y[VEL_W-1], a_vel_y};
	assign bx_e   = {b_vel_x[VEL_W-1], b_vel_x};
	assign by_e   = {b_vel_y[VEL_W-1], b_vel_y};
	assign msum   = {1'b0, a_mass} + {1'b0, b_mass};

	always_comb begin
		ctx_in.ax       = a_vel_x;
		ctx_in.ay       = a_vel_y;
		ctx_in.bx       = b_vel_x;
		ctx_in.by       = b_vel_y;
		ctx_in.nx_neg   = normal_x[VEL_W-1];
		ctx_in.ny_neg   = normal_y[VEL_W-1];
		ctx_in.nrm_zero = (mag_nx == '0) && (mag_ny == '0);
		ctx_in.a_inf    = a_mass_infinite;
		ctx_in.b_inf    = b_mass_infinite;
		ctx_in.sum_zero = (msum == '0);
		if (a_user_controlled) begin
			ctx_in.rx = -bx_e;
			ctx_in.ry = -by_e;
		end else if (b_user_controlled) begin
			ctx_in.rx = ax_e;
			ctx_in.ry = ay_e;
		end else begin
			ctx_in.rx = ax_e - bx_e;
			ctx_in.ry = ay_e - by_e;
		end
		if (a_mass_infinite && b_mass_infinite) begin
			ctx_in.err = ERR_BOTH_INF;
		end else if (a_user_controlled && b_user_controlled) begin
			ctx_in.err = ERR_BOTH_USER;
		end else begin
			ctx_in.err = ERR_OK;
		end
	end

	// Context delay line up to the back end.
	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s[1] <= ctx_in;
			for (int k = 2; k <= ST_UQ; k++) begin
				ctx_s[k] <= ctx_s[k-1];
			end
		end
	end

	// Normal length: normalize, square, sum, square root.
	ecr_nshift u_nshift (
		.clk    (clk),
		.en     (adv),
		.mag_x  (mag_nx),
		.mag_y  (mag_ny),
		.norm_x (nsx),
		.norm_y (nsy)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s3 <= {{MAG_W{1'b0}}, nsx} * {{MAG_W{1'b0}}, nsx};
			sqy_s3 <= {{MAG_W{1'b0}}, nsy} * {{MAG_W{1'b0}}, nsy};
			rad_s4 <= sqx_s3 + sqy_s3;
		end
	end

	ecr_sqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (rad_s4),
		.root (len)
	);

	// Normalized magnitudes wait for the length.
	always_ff @(posedge clk) begin
		if (adv) begin
			nm_s[ST_NSH+1] <= '{x: nsx, y: nsy};
			for (int k = ST_NSH + 2; k <= ST_LEN; k++) begin
				nm_s[k] <= nm_s[k-1];
			end
		end
	end

	// Unit normal magnitudes, with one extra quotient bit.
	ecr_div u_div_ux (
		.clk  (clk),
		.en   (adv),
		.den  ({1'b0, len}),
		.rem0 ({2'b00, nm_s[ST_LEN].x[MAG_W-1:1]}),
		.lo   ({nm_s[ST_LEN].x[0], {(DQW-1){1'b0}}}),
		.quo  (ux_quo)
	);

	ecr_div u_div_uy (
		.clk  (clk),
		.en   (adv),
		.den  ({1'b0, len}),
		.rem0 ({2'b00, nm_s[ST_LEN].y[MAG_W-1:1]}),
		.lo   ({nm_s[ST_LEN].y[0], {(DQW-1){1'b0}}}),
		.quo  (uy_quo)
	);

	// Mass weights: twice the other body's share of the total mass.
	ecr_div u_div_wa (
		.clk  (clk),
		.en   (adv),
		.den  (msum),
		.rem0 ({2'b00, b_mass[MASS_W-1:1]}),
		.lo   ({b_mass[0], {(DQW-1){1'b0}}}),
		.quo  (wa_quo)
	);

	ecr_div u_div_wb (
		.clk  (clk),
		.en   (adv),
		.den  (msum),
		.rem0 ({2'b00, a_mass[MASS_W-1:1]}),
		.lo   ({a_mass[0], {(DQW-1){1'b0}}}),
		.quo  (wb_quo)
	);

	// Weight selection for infinite masses and a zero mass sum.
	always_comb begin
		if (ctx_s[ST_WQ].b_inf) begin
			wgt_in.wa = W_TWO;
			wgt_in.wb = '0;
		end else if (ctx_s[ST_WQ].a_inf) begin
			wgt_in.wa = '0;
			wgt_in.wb = W_TWO;
		end else if (ctx_s[ST_WQ].sum_zero) begin
			wgt_in.wa = W_ONE;
			wgt_in.wb = W_ONE;
		end else begin
			wgt_in.wa = wa_quo;
			wgt_in.wb = wb_quo;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s[ST_W] <= wgt_in;
			for (int k = ST_W + 1; k <= ST_UQ; k++) begin
				w_s[k] <= w_s[k-1];
			end
		end
	end

	// Impulse back end and output register.
	ecr_resp u_resp (
		.clk         (clk),
		.en          (adv),
		.ctx         (ctx_s[ST_UQ]),
		.ux_quo      (ux_quo),
		.uy_quo      (uy_quo),
		.wgt         (w_s[ST_UQ]),
		.new_a_vel_x (new_a_vel_x),
		.new_a_vel_y (new_a_vel_y),
		.new_b_vel_x (new_b_vel_x),
		.new_b_vel_y (new_b_vel_y),
		.error_code  (error_code)
	);

endmodule

// ===== tb/tb_elastic_collision_response_2d.sv =====
// ----------------------------------------------------------------------------
// tb_elastic_collision_response_2d: self-checking bench for the 2D collision
// A directed table covers extremes, error codes and the degenerate normal,
// then random beats run through phases of sender and receiver idling. Every
// result beat is compared field by field with a fixed table value or an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_elastic_collision_response_2d;
	timeunit 1ns;
	timeprecision 1ps;
	import ecr_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int TAIL     = 80;

	typedef struct {
		logic signed [31:0] ax, ay, bx, by;
		logic [31:0]        ma, mb;
		logic               ainf, binf, auser, buser;
		logic signed [31:0] nx, ny;
	} coll_t;

	typedef struct {
		logic signed [31:0] ax, ay, bx, by;
		logic [ERR_W-1:0]   err;
	} resp_t;

	typedef struct {
		coll_t beat;
		bit    known;
		resp_t resp;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, out_ready = 0;
	logic in_ready, out_valid;
	logic signed [31:0] a_vel_x = 0, a_vel_y = 0, b_vel_x = 0, b_vel_y = 0;
	logic [31:0] a_mass = 1, b_mass = 1;
	logic a_mass_infinite = 0, b_mass_infinite = 0;
	logic a_user_controlled = 0, b_user_controlled = 0;
	logic signed [31:0] normal_x = 0, normal_y = 0;
	logic signed [31:0] new_a_vel_x, new_a_vel_y, new_b_vel_x, new_b_vel_y;
	logic [ERR_W-1:0] error_code;

	resp_t pending_resp[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	bit timed_out = 0;

	always #10 clk = ~clk;

	elastic_collision_response_2d dut (.*);

	// Floor division by 2^s for signed values.
	function automatic longint fl_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r = 0, b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Predicts the post-collision velocities for one beat.
	function automatic resp_t collide(coll_t c);
		resp_t o;
		longint ax = c.ax, ay = c.ay, bx = c.bx, by = c.by;
		longint nx = c.nx, ny = c.ny;
		longint rx, ry, ux = 0, uy = 0, p, wa, wb, qa, qb;
		longint unsigned mx, my, m, len, sum;
		int s = 0;
		o.ax = c.ax; o.ay = c.ay; o.bx = c.bx; o.by = c.by; o.err = ERR_OK;
		if (c.ainf && c.binf) begin
			o.err = ERR_BOTH_INF;
			return o;
		end
		if (c.auser && c.buser) begin
			o.err = ERR_BOTH_USER;
			return o;
		end
		mx = nx < 0 ? -nx : nx;
		my = ny < 0 ? -ny : ny;
		m = mx > my ? mx : my;
		if (c.auser) begin
			rx = -bx; ry = -by;
		end else if (c.buser) begin
			rx = ax; ry = ay;
		end else begin
			rx = ax - bx; ry = ay - by;
		end
		if (m != 0) begin
			while ((m << s) < (64'd1 << 30)) s++;
			mx <<= s;
			my <<= s;
			len = int_sqrt(mx * mx + my * my);
			ux = (mx << FRAC_BITS) / len;
			uy = (my << FRAC_BITS) / len;
			if (nx < 0) ux = -ux;
			if (ny < 0) uy = -uy;
		end
		p = fl_shr(rx * ux + ry * uy, FRAC_BITS);
		if (c.binf) begin
			wa = 64'sd2 << FRAC_BITS; wb = 0;
		end else if (c.ainf) begin
			wa = 0; wb = 64'sd2 << FRAC_BITS;
		end else begin
			sum = longint'(c.ma) + longint'(c.mb);
			if (sum == 0) begin
				wa = 64'sd1 << FRAC_BITS; wb = wa;
			end else begin
				wa = (longint'(c.mb) << (FRAC_BITS + 1)) / sum;
				wb = (longint'(c.ma) << (FRAC_BITS + 1)) / sum;
			end
		end
		qa = fl_shr(p * wa, FRAC_BITS);
		qb = fl_shr(p * wb, FRAC_BITS);
		o.ax = clamp32(ax - fl_shr(qa * ux, FRAC_BITS));
		o.ay = clamp32(ay - fl_shr(qa * uy, FRAC_BITS));
		o.bx = clamp32(bx + fl_shr(qb * ux, FRAC_BITS));
		o.by = clamp32(by + fl_shr(qb * uy, FRAC_BITS));
		return o;
	endfunction

	function automatic coll_t mk(int ax, int ay, int bx, int by, int unsigned ma,
		int unsigned mb, bit ai, bit bi, bit au, bit bu, int nx, int ny);
		coll_t c;
		c.ax = ax; c.ay = ay; c.bx = bx; c.by = by; c.ma = ma; c.mb = mb;
		c.ainf = ai; c.binf = bi; c.auser = au; c.buser = bu; c.nx = nx; c.ny = ny;
		return c;
	endfunction

	function automatic logic signed [31:0] rnd_vel();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] rnd_norm();
		case ($urandom_range(0, 6))
			0: return 0;
			1: return 32'sh80000000;
			2: return 32'sh7FFFFFFF;
			3: return $signed($urandom_range(0, 16)) - 8;
			4: return $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
			default: return $urandom;
		endcase
	endfunction

	function automatic coll_t rnd_coll();
		coll_t c;
		c.ax = rnd_vel(); c.ay = rnd_vel(); c.bx = rnd_vel(); c.by = rnd_vel();
		c.ma = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32'h20000) : $urandom;
		c.mb = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32'h20000) : $urandom;
		if (c.ma == 0) c.ma = 1;
		if (c.mb == 0) c.mb = 1;
		c.ainf = ($urandom_range(0, 5) == 0);
		c.binf = ($urandom_range(0, 5) == 0);
		c.auser = ($urandom_range(0, 5) == 0);
		c.buser = ($urandom_range(0, 5) == 0);
		c.nx = rnd_norm(); c.ny = rnd_norm();
		return c;
	endfunction

	// Presents one beat at the falling edge and holds it until accepted.
	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_beat(coll_t c);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		a_vel_x <= c.ax; a_vel_y <= c.ay; b_vel_x <= c.bx; b_vel_y <= c.by;
		a_mass <= c.ma; b_mass <= c.mb;
		a_mass_infinite <= c.ainf; b_mass_infinite <= c.binf;
		a_user_controlled <= c.auser; b_user_controlled <= c.buser;
		normal_x <= c.nx; normal_y <= c.ny;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic push_expected(resp_t r);
		pending_resp.push_back(r);
	endtask

	// Drops valid and waits at a falling edge until every result is back.
	task automatic drain();
		in_valid <= 0;
		while (pending_resp.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Receiver back-pressure, changed at the falling edge.
	always @(negedge clk) begin
		out_ready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
	end

	// Result check at the rising edge.
	always @(posedge clk) begin
		resp_t e;
		if (out_valid && out_ready) begin
			if (pending_resp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
			end else begin
				e = pending_resp.pop_front();
				if (e.ax !== new_a_vel_x || e.ay !== new_a_vel_y || e.bx !== new_b_vel_x
					|| e.by !== new_b_vel_y || e.err !== error_code) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d %0d %0d %0d err %0d, got %0d %0d %0d %0d err %0d",
							e.ax, e.ay, e.bx, e.by, e.err, new_a_vel_x, new_a_vel_y,
							new_b_vel_x, new_b_vel_y, error_code);
				end
			end
		end
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG && !timed_out) begin
			timed_out = 1;
			$display("tb_elastic_collision_response_2d: done, errors");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		coll_t c;
		resp_t pass;
		int phase_pct[4][2];
		phase_pct = '{'{0, 0}, '{54, 0}, '{0, 54}, '{26, 26}};
		rows.push_back('{mk(1, 2, 3, 4, 1, 1, 1, 1, 0, 0, 65536, 0), 1,
			'{1, 2, 3, 4, ERR_BOTH_INF}});
		rows.push_back('{mk(5, 6, 7, 8, 1, 1, 0, 0, 1, 1, 65536, 0), 1,
			'{5, 6, 7, 8, ERR_BOTH_USER}});
		rows.push_back('{mk(-1, 32'sh7FFFFFFF, 32'sh80000000, 9, 32'hFFFFFFFF, 1,
			1, 1, 1, 1, 0, 0), 1, '{-1, 32'sh7FFFFFFF, 32'sh80000000, 9, ERR_BOTH_INF}});
		// Zero-length normal leaves the velocities alone.
		rows.push_back('{mk(100, -200, 300, -400, 5, 7, 0, 0, 0, 0, 0, 0), 1,
			'{100, -200, 300, -400, ERR_OK}});
		rows.push_back('{mk(65536, 0, -65536, 0, 65536, 65536, 0, 0, 0, 0, 65536, 0), 0, pass});
		rows.push_back('{mk(65536, 0, 0, 0, 1, 1, 0, 1, 0, 0, 65536, 0), 0, pass});
		rows.push_back('{mk(0, 0, 65536, 65536, 1, 1, 1, 0, 0, 0, 1, 1), 0, pass});
		rows.push_back('{mk(65536, 0, 0, 0, 1, 1, 0, 0, 1, 0, -65536, 0), 0, pass});
		rows.push_back('{mk(65536, 0, 0, 0, 1, 1, 0, 0, 0, 1, 0, -1), 0, pass});
		rows.push_back('{mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
			32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF), 0, pass});
		rows.push_back('{mk(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			1, 32'hFFFFFFFF, 0, 0, 0, 0, 32'sh80000000, 32'sh80000000), 0, pass});
		rows.push_back('{mk(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
			1, 1, 0, 1, 0, 0, 32'sh80000000, 1), 0, pass});
		rows.push_back('{mk(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
			32'hFFFFFFFF, 1, 1, 0, 0, 0, -1, 32'sh7FFFFFFF), 0, pass});
		rows.push_back('{mk(-3, 7, 11, -13, 3, 5, 0, 0, 0, 0, 3, -4), 0, pass});

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		foreach (rows[i]) begin
			r = rows[i];
			push_expected(r.known ? r.resp : collide(r.beat));
			send_beat(r.beat);
		end
		// Sender holds off until the pipe is empty.
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = phase_pct[ph][0];
			recv_stall_pct = phase_pct[ph][1];
			for (int n = 0; n < 490; n++) begin
				c = rnd_coll();
				push_expected(collide(c));
				send_beat(c);
			end
		end
		recv_stall_pct = 0;
		drain();
		repeat (TAIL) @(posedge clk);
		if (mismatches == 0)
			$display("tb_elastic_collision_response_2d: done, clean");
		else
			$display("tb_elastic_collision_response_2d: done, errors");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/ecr_pkg.sv
rtl/ecr_nshift.sv
rtl/ecr_sqrt.sv
rtl/ecr_div.sv
rtl/ecr_resp.sv
rtl/elastic_collision_response_2d.sv
tb/tb_elastic_collision_response_2d.sv
